>>> design/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants of the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_SPLIT = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } front_stat_t;

  typedef struct packed {
    logic hold_valid;
    logic busy;
  } back_stat_t;

endpackage

>>> design/bed_front.sv
// ----------------------------------------------------------------------------
// bed_front
// Accepts input transfers, runs the escape decoder state and packs the
// one or two output bytes of an item into one queue entry (none for zero).
// ----------------------------------------------------------------------------
module bed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              suppress_newline,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        ch,
  input  logic              q_full,
  output logic              push,
  output bed_pkg::entry_t   push_entry,
  output bed_pkg::front_stat_t stat
);

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChC      = 8'h63;
  localparam logic [7:0] ChZero   = 8'h30;

  bed_pkg::mode_t mode, mode_next;
  logic [8:0]     oct_val, oct_val_next;
  logic [1:0]     oct_cnt, oct_cnt_next;
  logic           stopped, stopped_next;

  logic [1:0] n;
  logic [7:0] o0, o1;
  logic       accept;
  logic       is_digit;
  logic [8:0] oct_shift;
  logic [7:0] pend;
  logic       has_pend;
  logic       esc_hit;
  logic [7:0] esc_byte;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_digit  = (ch[7:3] == 5'b00110);
  assign oct_shift = {oct_val[5:0], ch[2:0]};
  assign has_pend  = (mode == bed_pkg::MODE_ESC) || (mode == bed_pkg::MODE_OCT);
  assign pend      = (mode == bed_pkg::MODE_ESC) ? ChBslash : oct_val[7:0];

  always_comb begin
    esc_hit  = 1'b1;
    esc_byte = 8'h00;
    case (ch)
      8'h61:    esc_byte = 8'h07;
      8'h62:    esc_byte = 8'h08;
      8'h66:    esc_byte = 8'h0C;
      8'h6E:    esc_byte = 8'h0A;
      8'h72:    esc_byte = 8'h0D;
      8'h74:    esc_byte = 8'h09;
      8'h76:    esc_byte = 8'h0B;
      8'h5C:    esc_byte = ChBslash;
      default:  esc_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    oct_val_next = oct_val;
    oct_cnt_next = oct_cnt;
    stopped_next = stopped;
    n  = 2'd0;
    o0 = 8'h00;
    o1 = 8'h00;
    case (bed_pkg::cmd_t'(cmd))
      bed_pkg::CMD_END: begin
        if (!stopped) begin
          if (has_pend) begin
            o0 = pend;
            o1 = ChNl;
            n  = suppress_newline ? 2'd1 : 2'd2;
          end else begin
            o0 = ChNl;
            n  = suppress_newline ? 2'd0 : 2'd1;
          end
        end
        mode_next    = bed_pkg::MODE_TEXT;
        oct_val_next = '0;
        oct_cnt_next = '0;
        stopped_next = 1'b0;
      end
      bed_pkg::CMD_SPLIT: begin
        if (!stopped) begin
          if (has_pend) begin
            o0 = pend;
            o1 = ChSpace;
            n  = 2'd2;
          end else begin
            o0 = ChSpace;
            n  = 2'd1;
          end
          mode_next    = bed_pkg::MODE_TEXT;
          oct_val_next = '0;
          oct_cnt_next = '0;
        end
      end
      bed_pkg::CMD_BYTE: begin
        if (!stopped) begin
          case (mode)
            bed_pkg::MODE_ESC: begin
              mode_next = bed_pkg::MODE_TEXT;
              if (esc_hit) begin
                o0 = esc_byte;
                n  = 2'd1;
              end else if (ch == ChC) begin
                stopped_next = 1'b1;
              end else if (ch == ChZero) begin
                mode_next    = bed_pkg::MODE_OCT;
                oct_val_next = '0;
                oct_cnt_next = '0;
              end else begin
                o0 = ChBslash;
                o1 = ch;
                n  = 2'd2;
              end
            end
            bed_pkg::MODE_OCT: begin
              if (is_digit) begin
                if (oct_cnt == 2'd2) begin
                  o0           = oct_shift[7:0];
                  n            = 2'd1;
                  mode_next    = bed_pkg::MODE_TEXT;
                  oct_val_next = '0;
                  oct_cnt_next = '0;
                end else begin
                  oct_val_next = oct_shift;
                  oct_cnt_next = oct_cnt + 2'd1;
                end
              end else begin
                o0           = oct_val[7:0];
                oct_val_next = '0;
                oct_cnt_next = '0;
                if (ch == ChBslash) begin
                  mode_next = bed_pkg::MODE_ESC;
                  n         = 2'd1;
                end else begin
                  mode_next = bed_pkg::MODE_TEXT;
                  o1        = ch;
                  n         = 2'd2;
                end
              end
            end
            default: begin
              if (ch == ChBslash) begin
                mode_next = bed_pkg::MODE_ESC;
              end else begin
                o0 = ch;
                n  = 2'd1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign push          = accept && (n != 2'd0);
  assign push_entry.two = n[1];
  assign push_entry.b0  = o0;
  assign push_entry.b1  = o1;
  assign stat.push      = push;
  assign stat.full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= bed_pkg::MODE_TEXT;
      oct_val <= '0;
      oct_cnt <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      oct_val <= oct_val_next;
      oct_cnt <= oct_cnt_next;
      stopped <= stopped_next;
    end
  end

endmodule

>>> design/bed_queue.sv
// ----------------------------------------------------------------------------
// bed_queue
// Small first-in first-out queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module bed_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bed_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bed_pkg::entry_t head
);

  bed_pkg::entry_t mem [bed_pkg::QDepth];

  logic [bed_pkg::QAw-1:0] wptr, rptr;
  logic [bed_pkg::QAw:0]   cnt;
  logic                    do_pop;

  assign full       = (cnt == (bed_pkg::QAw+1)'(bed_pkg::QDepth));
  assign head_valid = (cnt != '0);
  assign head       = mem[rptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> design/bed_back.sv
// ----------------------------------------------------------------------------
// bed_back
// Drains queue entries into the output register, one byte per transfer,
// holding the second byte of a two-byte entry in a side register.
// ----------------------------------------------------------------------------
module bed_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  bed_pkg::entry_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last_of_run,
  output bed_pkg::back_stat_t stat
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !hold_valid && head_valid;

  assign stat.hold_valid = hold_valid;
  assign stat.busy       = out_valid || hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (head_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= head.two;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        out_byte    <= hold_byte;
        last_of_run <= 1'b1;
      end else if (head_valid) begin
        out_byte    <= head.b0;
        last_of_run <= !head.two;
        hold_byte   <= head.b1;
      end
    end
  end

endmodule

>>> design/backslash_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// Echo-style backslash escape decoder. Takes one input transfer per cycle as
// long as the four-entry queue between the decoder front and the output back
// has room; an accepted item is written into the queue and is then loaded
// into the output register. The output register gives one byte per cycle
// while out_ready is high, so an item that decodes to two bytes occupies it
// for both bytes, and a long run of such items is limited by the single
// output register. Items that decode to nothing push no queue entry.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic                  suppress_newline;
  logic                  q_full;
  logic                  push;
  bed_pkg::entry_t       push_entry;
  logic                  pop;
  logic                  head_valid;
  bed_pkg::entry_t       head;
  bed_pkg::front_stat_t  front_stat;
  bed_pkg::back_stat_t   back_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      suppress_newline <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      suppress_newline <= cfg_data;
    end
  end

  bed_front u_front (
    .clk              (clk),
    .rst              (rst),
    .suppress_newline (suppress_newline),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .ch               (ch),
    .q_full           (q_full),
    .push             (push),
    .push_entry       (push_entry),
    .stat             (front_stat)
  );

  bed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stat        (back_stat)
  );

  a_hold_behind_first: assert property (@(posedge clk) disable iff (rst)
    back_stat.hold_valid |-> (out_valid && !last_of_run))
    else $error("second byte held without a first byte on the output");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    front_stat.push |-> !front_stat.full)
    else $error("queue push while full");

  a_pair_completes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && back_stat.hold_valid) |=> (out_valid && last_of_run))
    else $error("second byte of a pair not presented after the first");

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    !back_stat.busy |-> !out_valid)
    else $error("output valid while back end idle");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the echo escape decoder end to end. A directed opener covers byte
// extremes, each command, the escape forms, cut-short octal runs, stop
// escapes and ignored commands; random commands made of escaped arguments
// follow, with noise, random gaps on both sides and newline setting changes.
// A scoreboard predicts every output byte and its run mark.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_STOP      = 8'h63;
  localparam int ITEM_TARGET = 1500;
  localparam int SETTLE      = 10;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_byte_t;

  class echo_scoreboard;
    out_byte_t      expected[$];
    logic [7:0]     step_bytes[$];
    bed_pkg::mode_t mode;
    logic [8:0]     oct_value;
    logic [1:0]     oct_count;
    bit             stopped;
    bit             nl_off;
    int             errors;

    function new();
      nl_off = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = bed_pkg::MODE_TEXT;
      oct_value = '0;
      oct_count = '0;
      stopped = 1'b0;
    endfunction

    function void text_byte(logic [7:0] b);
      if (b == CH_BACKSLASH) mode = bed_pkg::MODE_ESC;
      else step_bytes.push_back(b);
    endfunction

    function void flush_pending();
      if (mode == bed_pkg::MODE_ESC) step_bytes.push_back(CH_BACKSLASH);
      else if (mode == bed_pkg::MODE_OCT) step_bytes.push_back(oct_value[7:0]);
      mode = bed_pkg::MODE_TEXT;
      oct_value = '0;
      oct_count = '0;
    endfunction

    function void note_transfer(bed_pkg::cmd_t c, logic [7:0] b);
      step_bytes = {};
      if (c == bed_pkg::CMD_END) begin
        if (!stopped) begin
          flush_pending();
          if (!nl_off) step_bytes.push_back(CH_NEWLINE);
        end
        clear();
      end else if (c != bed_pkg::CMD_NONE && !stopped) begin
        if (c == bed_pkg::CMD_SPLIT) begin
          flush_pending();
          step_bytes.push_back(CH_SPACE);
        end else if (mode == bed_pkg::MODE_ESC) begin
          mode = bed_pkg::MODE_TEXT;
          case (b)
            "a": step_bytes.push_back(8'h07);
            "b": step_bytes.push_back(8'h08);
            "f": step_bytes.push_back(8'h0C);
            "n": step_bytes.push_back(8'h0A);
            "r": step_bytes.push_back(8'h0D);
            "t": step_bytes.push_back(8'h09);
            "v": step_bytes.push_back(8'h0B);
            CH_BACKSLASH: step_bytes.push_back(CH_BACKSLASH);
            CH_STOP: stopped = 1'b1;
            CH_ZERO: begin
              mode = bed_pkg::MODE_OCT;
              oct_value = '0;
              oct_count = '0;
            end
            default: begin
              step_bytes.push_back(CH_BACKSLASH);
              text_byte(b);
            end
          endcase
        end else if (mode == bed_pkg::MODE_OCT) begin
          if (b >= CH_ZERO && b <= CH_SEVEN) begin
            oct_value = {oct_value[5:0], b[2:0]};
            oct_count = oct_count + 2'd1;
            if (oct_count == 2'd3) flush_pending();
          end else begin
            flush_pending();
            text_byte(b);
          end
        end else begin
          text_byte(b);
        end
      end
      foreach (step_bytes[i])
        expected.push_back(out_byte_t'{step_bytes[i], i == step_bytes.size() - 1});
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      out_byte_t e;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output byte %h last %b", $time, b, last);
        return;
      end
      e = expected.pop_front();
      if (b !== e.value) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: out_byte expected %h actual %h", $time, e.value, b);
      end
      if (last !== e.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = bed_pkg::CMD_BYTE;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  echo_scoreboard sb = new();
  int items_sent = 0;
  bit rush_in = 1'b0;
  bit rush_out = 1'b0;
  logic [7:0] known_esc[8] = '{"a", "b", "f", "n", "r", "t", "v", CH_BACKSLASH};

  backslash_escape_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_byte(out_byte, last_of_run);
      if (in_valid && in_ready) sb.note_transfer(bed_pkg::cmd_t'(cmd), ch);
      if (cfg_valid && cfg_ready) sb.nl_off = cfg_data;
    end
  end

  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = rush_out ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic send_item(bed_pkg::cmd_t c, logic [7:0] b);
    int gap;
    gap = rush_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    ch = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (c != bed_pkg::CMD_NONE) items_sent++;
  endtask

  task automatic send_str(string s);
    foreach (s[i]) send_item(bed_pkg::CMD_BYTE, s[i]);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(logic v);
    drain();
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_argument();
    int kind;
    int digits;
    logic [7:0] d;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_item(bed_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end else if (kind < 98) begin
        send_item(bed_pkg::CMD_BYTE, CH_BACKSLASH);
        if (kind < 62) begin
          send_item(bed_pkg::CMD_BYTE, known_esc[$urandom_range(0, 7)]);
        end else if (kind < 72) begin
          send_item(bed_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
          send_item(bed_pkg::CMD_BYTE, CH_ZERO);
          digits = $urandom_range(0, 3);
          repeat (digits) begin
            d = 8'(CH_ZERO + $urandom_range(0, 7));
            send_item(bed_pkg::CMD_BYTE, d);
          end
        end else if (kind < 94) begin
          send_item(bed_pkg::CMD_BYTE, CH_STOP);
        end
      end else begin
        send_item(bed_pkg::CMD_BYTE, $urandom_range(0, 1) ? 8'h38 : 8'h39);
      end
    end
  endtask

  task automatic send_command();
    int nargs;
    nargs = $urandom_range(1, 4);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) send_item(bed_pkg::CMD_SPLIT, 8'($urandom_range(0, 255)));
      send_argument();
    end
    send_item(bed_pkg::CMD_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(bed_pkg::CMD_BYTE, 8'h00);
    send_item(bed_pkg::CMD_BYTE, 8'hFF);
    send_str("\\t\\q\\");
    send_item(bed_pkg::CMD_SPLIT, 8'hFF);
    send_str("\\0123\\07z\\0");
    send_item(bed_pkg::CMD_END, 8'h00);
    write_cfg(1'b1);
    send_str("x\\");
    send_item(bed_pkg::CMD_END, 8'hFF);
    write_cfg(1'b0);
    send_str("\\cx");
    send_item(bed_pkg::CMD_SPLIT, 8'h00);
    send_item(bed_pkg::CMD_END, 8'h00);
    send_item(bed_pkg::CMD_NONE, 8'hA5);
    send_item(bed_pkg::CMD_END, 8'h5A);

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(bed_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_command();
      end
      if ($urandom_range(0, 7) == 0) write_cfg(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) rush_in = ~rush_in;
      if ($urandom_range(0, 5) == 0) rush_out = ~rush_out;
    end

    drain();
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bed_pkg.sv
design/bed_front.sv
design/bed_queue.sv
design/bed_back.sv
design/backslash_escape_decoder_core.sv
bench/testbench.sv
